/* design/dct_pkg.sv */
// Shared types and constants for the dark channel transmission block.
// Used by dct_ctrl, dct_dp and dark_channel_transmission; no dependencies.
`default_nettype none
package dct_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_RADIUS   = 8;
    localparam int RING_ROWS    = 2 * MAX_RADIUS + 2;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LS_DEPTH     = RING_ROWS * MAX_WIDTH;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int RMOD_W  = $clog2(RING_ROWS);
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
    localparam int ADDR_W  = RMOD_W + COL_W;
    localparam int CNT_W   = $clog2(MAX_WIDTH * HEIGHT_LIMIT) + 1;
    localparam int WCFG_W  = 11;
    localparam int HCFG_W  = 13;
    localparam int RCFG_W  = 4;
    localparam int RECIP_W = 24;
    localparam int IDX_W   = 3;

    localparam logic [15:0] ONE_Q15 = 16'd32768;
    // floor(y / 5) = (y * DIV5_MUL) >> DIV5_SHIFT for y below 2^22
    localparam logic [19:0] DIV5_MUL   = 20'd838861;
    localparam int          DIV5_SHIFT = 22;

    typedef enum logic [IDX_W-1:0] {
        CFG_RECIP_BLUE   = 3'd0,
        CFG_RECIP_GREEN  = 3'd1,
        CFG_RECIP_RED    = 3'd2,
        CFG_RADIUS       = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } t_chan;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL0  = 10'b00_0000_0010,
        ST_MUL1  = 10'b00_0000_0100,
        ST_MUL2  = 10'b00_0000_1000,
        ST_WRITE = 10'b00_0001_0000,
        ST_CHECK = 10'b00_0010_0000,
        ST_SCAN  = 10'b00_0100_0000,
        ST_DRAIN = 10'b00_1000_0000,
        ST_DIV   = 10'b01_0000_0000,
        ST_RES   = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic  accept;
        logic  mul_en;
        t_chan mul_sel;
        logic  write_px;
        logic  scan_init;
        logic  scan_read;
        logic  div_en;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* design/dct_ctrl.sv */
// Sequencer for the dark channel transmission block.
// Depends on dct_pkg; drives dct_dp through t_cmd and reads t_stat.
`default_nettype none
module dct_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_mode,
    output logic                o_ready,
    input  wire dct_pkg::t_stat i_stat,
    output dct_pkg::t_cmd       o_cmd
);
    import dct_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = CH_BLUE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_mode ? ST_CHECK : ST_MUL0;
                end
            end
            ST_MUL0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = CH_BLUE;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = CH_GREEN;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = CH_RED;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write_px = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.due) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state = ST_RES;
            end
            ST_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/dct_dp.sv */
// Datapath: channel scaling, line store, window scan, transmission and output register.
// Depends on dct_pkg; commanded by dct_ctrl.
`default_nettype none
module dct_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_restart,
    input  wire logic [dct_pkg::RECIP_W-1:0]   i_recip_blue,
    input  wire logic [dct_pkg::RECIP_W-1:0]   i_recip_green,
    input  wire logic [dct_pkg::RECIP_W-1:0]   i_recip_red,
    input  wire logic [dct_pkg::RCFG_W-1:0]    i_radius,
    input  wire logic [dct_pkg::WCFG_W-1:0]    i_width,
    input  wire logic [dct_pkg::HCFG_W-1:0]    i_height,
    input  wire logic                          i_mode,
    input  wire logic [7:0]                    i_blue,
    input  wire logic [7:0]                    i_green,
    input  wire logic [7:0]                    i_red,
    input  wire dct_pkg::t_cmd                 i_cmd,
    output dct_pkg::t_stat                     o_stat,
    output logic                               o_valid,
    input  wire logic                          i_out_ready,
    output logic [15:0]                        o_transmission,
    output logic [15:0]                        o_running_min,
    output logic [15:0]                        o_running_max,
    output logic                               o_end_of_frame
);
    import dct_pkg::*;

    // frame geometry
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  lag;
    logic [CNT_W-1:0]  pending;

    // frame counters
    logic [CNT_W-1:0]  r_in_count;
    logic [COL_W-1:0]  r_in_col;
    logic [RMOD_W-1:0] r_in_rmod;
    logic [CNT_W-1:0]  r_out_index;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [RMOD_W-1:0] r_out_rmod;
    logic [15:0]       r_min;
    logic [15:0]       r_max;

    // pixel and dark value
    logic [7:0]  r_blue, r_green, r_red;
    logic [7:0]  chan;
    logic [RECIP_W-1:0] recip;
    logic [32:0] prod;
    logic [24:0] q;
    logic [15:0] q_sat;
    logic [15:0] r_dark;

    // window scan
    logic [ROW_W-1:0]  r_y, r_y_end;
    logic [RMOD_W-1:0] r_y_mod;
    logic [COL_W-1:0]  r_x, r_x_beg, r_x_end;
    logic [15:0]       r_acc;
    logic [15:0]       r_rdata;
    logic              r_rd_vld;
    logic [ROW_W:0]    row_hi;
    logic [ROW_W-1:0]  row_lo, row_top;
    logic [COL_W:0]    col_hi;
    logic [COL_W-1:0]  col_lo, col_top;
    logic [RMOD_W-1:0] rmod_back, rmod_lo;

    // transmission
    logic [20:0] dark19;
    logic [38:0] qprod;
    logic [15:0] r_quot;
    logic [15:0] trans;
    logic [15:0] new_min, new_max;
    logic        last;
    logic        frame_restart;

    logic [15:0] mem [0:LS_DEPTH-1];

    assign total   = CNT_W'(i_width) * CNT_W'(i_height);
    assign lag     = CNT_W'(i_radius) * CNT_W'(i_width) + CNT_W'(i_radius);
    assign pending = r_in_count - r_out_index;

    assign o_stat.due = (r_out_index < total) &&
                        ((r_in_count >= total) || (pending > lag));
    assign o_stat.scan_last = (r_x == r_x_end) && (r_y == r_y_end);
    assign o_stat.out_free  = !o_valid || i_out_ready;

    // channel scaling, one channel a cycle
    always_comb begin
        case (i_cmd.mul_sel)
            CH_BLUE:  begin chan = r_blue;  recip = i_recip_blue;  end
            CH_GREEN: begin chan = r_green; recip = i_recip_green; end
            CH_RED:   begin chan = r_red;   recip = i_recip_red;   end
            default:  begin chan = r_blue;  recip = i_recip_blue;  end
        endcase
    end
    assign prod  = 33'(chan) * 33'(recip) + 33'd128;
    assign q     = prod[32:8];
    assign q_sat = (q > 25'(ONE_Q15)) ? ONE_Q15 : q[15:0];

    // window bounds for the next result
    assign row_hi  = (ROW_W+1)'(r_out_row) + (ROW_W+1)'(i_radius);
    assign row_lo  = (r_out_row >= ROW_W'(i_radius)) ? r_out_row - ROW_W'(i_radius) : '0;
    assign row_top = (row_hi < (ROW_W+1)'(i_height)) ? row_hi[ROW_W-1:0]
                                                     : ROW_W'(i_height - 1'b1);
    assign col_hi  = (COL_W+1)'(r_out_col) + (COL_W+1)'(i_radius);
    assign col_lo  = (r_out_col >= COL_W'(i_radius)) ? r_out_col - COL_W'(i_radius) : '0;
    assign col_top = (col_hi < (COL_W+1)'(i_width)) ? col_hi[COL_W-1:0]
                                                    : COL_W'(i_width - 1'b1);
    assign rmod_back = RMOD_W'(r_out_row - row_lo);
    assign rmod_lo   = (r_out_rmod >= rmod_back) ? r_out_rmod - rmod_back
                     : RMOD_W'(r_out_rmod + RMOD_W'(RING_ROWS) - rmod_back);

    // (19*dark + 10) / 20 as ((19*dark + 10) >> 2) / 5
    assign dark19 = 21'(r_acc) * 21'd19 + 21'd10;
    assign qprod  = 39'(dark19[20:2]) * 39'(DIV5_MUL);

    assign trans   = ONE_Q15 - r_quot;
    assign new_min = (trans < r_min) ? trans : r_min;
    assign new_max = (trans > r_max) ? trans : r_max;
    assign last    = (r_out_index == total - 1'b1);

    assign frame_restart = i_cmd.accept && !i_mode && (r_in_count >= total);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_px) begin
            mem[{r_in_rmod, r_in_col}] <= r_dark;
        end
        r_rdata <= mem[{r_y_mod, r_x}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == CH_BLUE || q_sat < r_dark) begin
                r_dark <= q_sat;
            end
        end
        if (i_cmd.div_en) begin
            r_quot <= qprod[DIV5_SHIFT +: 16];
        end
        if (i_cmd.load_out) begin
            o_transmission <= trans;
            o_running_min  <= new_min;
            o_running_max  <= new_max;
            o_end_of_frame <= last;
        end
    end

    // window scan: issue one read a cycle, fold the registered data in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_read;
        end
        if (i_cmd.scan_init) begin
            r_y     <= row_lo;
            r_y_end <= row_top;
            r_y_mod <= rmod_lo;
            r_x     <= col_lo;
            r_x_beg <= col_lo;
            r_x_end <= col_top;
            r_acc   <= ONE_Q15;
        end else begin
            if (i_cmd.scan_read) begin
                if (r_x == r_x_end) begin
                    r_x <= r_x_beg;
                    r_y <= r_y + 1'b1;
                    r_y_mod <= (r_y_mod == RMOD_W'(RING_ROWS - 1)) ? '0 : r_y_mod + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (r_rd_vld && r_rdata < r_acc) begin
                r_acc <= r_rdata;
            end
        end
    end

    // frame position and running extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || frame_restart ||
            (i_cmd.load_out && last)) begin
            r_in_count  <= '0;
            r_in_col    <= '0;
            r_in_rmod   <= '0;
            r_out_index <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_rmod  <= '0;
            r_min       <= ONE_Q15;
            r_max       <= '0;
        end else begin
            if (i_cmd.write_px) begin
                r_in_count <= r_in_count + 1'b1;
                if ((COL_W+1)'(r_in_col) == (COL_W+1)'(i_width - 1'b1)) begin
                    r_in_col  <= '0;
                    r_in_rmod <= (r_in_rmod == RMOD_W'(RING_ROWS - 1)) ? '0
                                                                       : r_in_rmod + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_min       <= new_min;
                r_max       <= new_max;
                r_out_index <= r_out_index + 1'b1;
                if ((COL_W+1)'(r_out_col) == (COL_W+1)'(i_width - 1'b1)) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + 1'b1;
                    r_out_rmod <= (r_out_rmod == RMOD_W'(RING_ROWS - 1)) ? '0
                                                                         : r_out_rmod + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* design/dark_channel_transmission.sv */
// Top level of the dark channel transmission block: configuration registers and wiring.
// Depends on dct_pkg, dct_ctrl and dct_dp.
`default_nettype none
// Streams 8-bit BGR pixels in raster order and returns, for each pixel, the
// transmission 1 - 0.95*dark in Q1.15, where dark is the minimum of the three
// channels (each scaled by its reciprocal register and saturated at 1.0) taken
// over a square window of the configured radius, clipped at the frame borders.
// Each result also carries the running minimum and maximum transmission of the
// frame and an end-of-frame mark on tlast. Results trail the input by
// radius*width+radius words; send flush words (tuser = 1) to drain the tail.
// The block takes no new word until it is done with the last: a pixel word has
// its three channels scaled in turn and its dark value written to the line store;
// then, if a result is due, the window (17 x 17 at radius 8) is read from the line
// store one entry a cycle, the minimum is divided and the result is loaded into the
// output word. A flush word only checks for a due result. A stalled result side
// holds the block until the output word is free. A write to any of the six
// configuration registers restarts the frame; write only while the block is idle.
// The line store needs no clearing pass after reset.
module dark_channel_transmission (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [dct_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [dct_pkg::RECIP_W-1:0]   i_cfg_data,
    // pixel stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  wire logic                          s_tuser,   // mode: 0 pixel, 1 flush
    // transmission stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,   // transmission, running_min, running_max
    output logic                               m_tlast    // end_of_frame
);
    import dct_pkg::*;

    logic [RECIP_W-1:0] r_recip_blue, r_recip_green, r_recip_red;
    logic [RCFG_W-1:0]  r_radius;
    logic [WCFG_W-1:0]  r_image_width;
    logic [HCFG_W-1:0]  r_image_height;

    logic [RCFG_W-1:0]  eff_radius;
    logic [WCFG_W-1:0]  eff_width;
    logic [HCFG_W-1:0]  eff_height;
    logic               cfg_restart;

    t_cmd  cmd;
    t_stat stat;

    // hold register writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_blue   <= RECIP_W'(32896);
            r_recip_green  <= RECIP_W'(32896);
            r_recip_red    <= RECIP_W'(32896);
            r_radius       <= RCFG_W'(7);
            r_image_width  <= WCFG_W'(640);
            r_image_height <= HCFG_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECIP_BLUE:   r_recip_blue   <= i_cfg_data;
                CFG_RECIP_GREEN:  r_recip_green  <= i_cfg_data;
                CFG_RECIP_RED:    r_recip_red    <= i_cfg_data;
                CFG_RADIUS:       r_radius       <= i_cfg_data[RCFG_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WCFG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_restart = i_cfg_we && (i_cfg_index <= CFG_IMAGE_HEIGHT);

    // clamp the geometry to what the line store supports
    assign eff_radius = (r_radius > RCFG_W'(MAX_RADIUS)) ? RCFG_W'(MAX_RADIUS) : r_radius;
    assign eff_width  = (r_image_width == '0) ? WCFG_W'(1)
                      : (r_image_width > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH)
                      : r_image_width;
    assign eff_height = (r_image_height == '0) ? HCFG_W'(1)
                      : (r_image_height > HCFG_W'(HEIGHT_LIMIT)) ? HCFG_W'(HEIGHT_LIMIT)
                      : r_image_height;

    dct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_mode  (s_tuser),
        .o_ready (s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_restart),
        .i_recip_blue   (r_recip_blue),
        .i_recip_green  (r_recip_green),
        .i_recip_red    (r_recip_red),
        .i_radius       (eff_radius),
        .i_width        (eff_width),
        .i_height       (eff_height),
        .i_mode         (s_tuser),
        .i_blue         (s_tdata[7:0]),
        .i_green        (s_tdata[15:8]),
        .i_red          (s_tdata[23:16]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (m_tvalid),
        .i_out_ready    (m_tready),
        .o_transmission (m_tdata[15:0]),
        .o_running_min  (m_tdata[31:16]),
        .o_running_max  (m_tdata[47:32]),
        .o_end_of_frame (m_tlast)
    );

endmodule
`default_nettype wire

/* bench/tb_dark_channel_transmission.sv */
// Self-checking bench for dark_channel_transmission: directed and random pixel streams.
// Depends on dct_pkg and the design files; predicts every transmission word in-bench.
`timescale 1ns / 100ps
`default_nettype none
module tb_dark_channel_transmission;
    import dct_pkg::*;

    localparam int STALL_LIMIT = 200000;   // idle cycles before giving up

    typedef struct packed {
        logic [15:0] trans;
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic        eof;
    } t_trans_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [RECIP_W-1:0]   i_cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tlast;

    dark_channel_transmission i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow registers and frame state of the predictor
    logic [23:0] sh_recip [3];
    logic [3:0]  sh_radius;
    logic [10:0] sh_width;
    logic [12:0] sh_height;
    int unsigned pos_col, pos_row, next_out, low_mark, high_mark;
    logic [15:0] dark_rows [RING_ROWS*MAX_WIDTH];

    t_trans_word expected_words[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic int unsigned eff_radius();
        return (sh_radius > MAX_RADIUS) ? MAX_RADIUS : sh_radius;
    endfunction

    function automatic int unsigned eff_width();
        if (sh_width == 0) return 1;
        return (sh_width > MAX_WIDTH) ? MAX_WIDTH : sh_width;
    endfunction

    function automatic int unsigned eff_height();
        if (sh_height == 0) return 1;
        return (sh_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : sh_height;
    endfunction

    function automatic int unsigned scaled(input logic [7:0] c, input logic [23:0] rc);
        longint unsigned q;
        q = (longint'(c) * longint'(rc) + 128) >> 8;
        return (q > 32768) ? 32768 : int'(q);
    endfunction

    function automatic void restart_frame();
        pos_col = 0;
        pos_row = 0;
        next_out = 0;
        low_mark = 32768;
        high_mark = 0;
    endfunction

    // Advance the predictor by one accepted word; queue the transmission it yields
    function automatic void predict_word(input logic flush, input logic [23:0] px);
        int unsigned w, h, r, total, lag, got, b, g, rd, dk, oi, oj, r0, r1, c0, c1, t;
        t_trans_word tw;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        total = w * h;
        lag = r * w + r;
        got = pos_row * w + pos_col;
        if (!flush) begin
            if (got >= total) begin
                restart_frame();
                got = 0;
            end
            b = scaled(px[7:0], sh_recip[CH_BLUE]);
            g = scaled(px[15:8], sh_recip[CH_GREEN]);
            rd = scaled(px[23:16], sh_recip[CH_RED]);
            dk = (b < g) ? b : g;
            if (rd < dk) dk = rd;
            dark_rows[(pos_row % RING_ROWS) * MAX_WIDTH + pos_col] = dk[15:0];
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
            end
            got++;
        end
        if (next_out < total && (got >= total || got - next_out > lag)) begin
            oi = next_out / w;
            oj = next_out % w;
            r0 = (oi >= r) ? oi - r : 0;
            r1 = (oi + r < h) ? oi + r : h - 1;
            c0 = (oj >= r) ? oj - r : 0;
            c1 = (oj + r < w) ? oj + r : w - 1;
            dk = 32768;
            for (int unsigned y = r0; y <= r1; y++)
                for (int unsigned x = c0; x <= c1; x++)
                    if (dark_rows[(y % RING_ROWS) * MAX_WIDTH + x] < dk)
                        dk = dark_rows[(y % RING_ROWS) * MAX_WIDTH + x];
            t = 32768 - (dk * 19 + 10) / 20;
            if (t < low_mark) low_mark = t;
            if (t > high_mark) high_mark = t;
            tw.trans = t[15:0];
            tw.tmin = low_mark[15:0];
            tw.tmax = high_mark[15:0];
            tw.eof = (next_out == total - 1);
            expected_words.insert(expected_words.size(), tw);
            next_out++;
            if (tw.eof) restart_frame();
        end
    endfunction

    // Drain everything outstanding, then let a stray flush settle
    task automatic wait_idle();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RECIP_BLUE:   sh_recip[CH_BLUE] = value;
            CFG_RECIP_GREEN:  sh_recip[CH_GREEN] = value;
            CFG_RECIP_RED:    sh_recip[CH_RED] = value;
            CFG_RADIUS:       sh_radius = value[3:0];
            CFG_IMAGE_WIDTH:  sh_width = value[10:0];
            default:          sh_height = value[12:0];
        endcase
        restart_frame();
    endtask

    task automatic set_frame(input int r, input int w, input int h);
        write_reg(CFG_RADIUS, 24'(r));
        write_reg(CFG_IMAGE_WIDTH, 24'(w));
        write_reg(CFG_IMAGE_HEIGHT, 24'(h));
    endtask

    // Offer one word, holding it until accepted; idle first at the sender rate.
    // The block is never ready in the cycle after an accept, so the one-cycle
    // drop of tvalid between words costs no throughput.
    task automatic send_word(input logic flush, input logic [23:0] px);
        @(posedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser <= flush;
        s_tdata <= px;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_word(flush, px);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // One frame plus the flushes that drain its tail
    task automatic send_frame(input int pixels, input int flushes);
        repeat (pixels) send_word(1'b0, rand_pixel());
        repeat (flushes) send_word(1'b1, 24'($urandom));
    endtask

    // Result side: stall at random, check each accepted word in order
    always @(posedge i_clk) begin
        t_trans_word got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = expected_words.pop_front();
                if (got.trans !== want.trans)
                    report($sformatf("transmission %0d want %0d", got.trans, want.trans));
                if (got.tmin !== want.tmin)
                    report($sformatf("running min %0d want %0d", got.tmin, want.tmin));
                if (got.tmax !== want.tmax)
                    report($sformatf("running max %0d want %0d", got.tmax, want.tmax));
                if (got.eof !== want.eof)
                    report($sformatf("end of frame %0b want %0b", got.eof, want.eof));
            end
        end
        m_tready <= !hold_off &&
                    !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: give up after a long run with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Corners: saturating and zero reciprocals, black and white pixels, radius 0
    task automatic test_directed();
        write_reg(CFG_RECIP_BLUE, 24'd8388608);
        write_reg(CFG_RECIP_GREEN, 24'd0);
        write_reg(CFG_RECIP_RED, 24'd32896);
        set_frame(0, 3, 2);
        send_word(1'b1, 24'h0);                  // flush with nothing due
        send_word(1'b0, 24'h000000);
        send_word(1'b0, 24'hFFFFFF);
        send_word(1'b0, 24'hFF00FF);
        send_word(1'b0, 24'h00FF00);
        send_word(1'b0, 24'h808080);
        send_word(1'b0, 24'h7F017F);
        write_reg(CFG_RECIP_GREEN, 24'd65000);
        set_frame(1, 2, 2);
        send_frame(4, 4);
        // new frame abandons an undrained tail
        send_frame(3, 0);
        send_word(1'b0, 24'hFFFFFF);
        send_frame(2, 6);
    endtask

    // Random frames at small sizes, with the odd large width and register extremes
    task automatic test_random(input int pixels);
        int sent = 0;
        int w, h, n, tail;
        while (sent < pixels) begin
            write_reg(t_cfg_idx'($urandom_range(2)),
                      ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 40000)));
            w = ($urandom_range(19) == 0) ? $urandom_range(1000, 1100) : $urandom_range(0, 12);
            h = ($urandom_range(9) == 0) ? 5000 : $urandom_range(0, 8);
            if (w > 20) h = $urandom_range(1, 2);
            set_frame($urandom_range(0, 15), w, h);
            n = int'(eff_width() * eff_height());
            if (n > pixels - sent) n = pixels - sent;
            tail = int'(eff_radius() * eff_width() + eff_radius());
            if (tail > n) tail = n;
            send_frame(n, tail + int'($urandom_range(2)));
            sent += n + tail;
        end
    endtask

    // Stall the result side for long while pixels keep coming
    task automatic test_backpressure();
        write_reg(CFG_RECIP_BLUE, 24'd40000);
        set_frame(2, 8, 8);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_frame(64, 18);
        join
        wait_idle();
        send_frame(40, 0);
        while (expected_words.size() != 0) @(posedge i_clk);  // sender waits out the results
        send_frame(24, 18);
    endtask

    initial begin
        sh_recip[CH_BLUE] = 24'd32896;
        sh_recip[CH_GREEN] = 24'd32896;
        sh_recip[CH_RED] = 24'd32896;
        sh_radius = 4'd7;
        sh_width = 11'd640;
        sh_height = 13'd480;
        restart_frame();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(350);
        send_idle_pct = 71;
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        test_random(300);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        test_random(300);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* dark_channel_transmission.f */
design/dct_pkg.sv
design/dct_ctrl.sv
design/dct_dp.sv
design/dark_channel_transmission.sv
bench/tb_dark_channel_transmission.sv
